### hdl/hec_pkg.sv
// ----------------------------------------------------------------------------
// hec_pkg
// Shared types and constants for the homogeneous edge clipper pipeline.
// ----------------------------------------------------------------------------
package hec_pkg;

    // Clip planes w+x, w-x, w+y, w-y, w+z, w-z
    localparam int NUM_PLANES = 6;

    // Position of w inside one endpoint (x, y, z, w)
    localparam int W_AXIS = 3;

    // Control that travels with an item through a plane
    typedef struct packed {
        logic       valid;   // stage holds an item
        logic       kept;    // edge still alive
        logic       active;  // this plane moves one endpoint
        logic       move_a;  // moved endpoint is the start point
        logic [3:0] dneg;    // per axis: offset toward the other endpoint is negative
    } hec_ctl_t;

endpackage

### hdl/hec_div_step.sv
// ----------------------------------------------------------------------------
// hec_div_step
// One restoring division step for the four axis lanes of a plane: one
// quotient bit per lane, registered, with the item's points carried along.
// ----------------------------------------------------------------------------
module hec_div_step #(
    parameter int CW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  hec_pkg::hec_ctl_t     in_ctl,
    input  logic [7:0][CW-1:0]    in_pts,
    input  logic [CW+1:0]         in_den,
    input  logic [3:0][CW+1:0]    in_rem,
    input  logic [3:0][CW-1:0]    in_sh,
    output hec_pkg::hec_ctl_t     out_ctl,
    output logic [7:0][CW-1:0]    out_pts,
    output logic [CW+1:0]         out_den,
    output logic [3:0][CW+1:0]    out_rem,
    output logic [3:0][CW-1:0]    out_sh
);

    localparam int VW = CW + 2;

    hec_pkg::hec_ctl_t     ctl_reg;
    logic [7:0][CW-1:0]    pts_reg;
    logic [VW-1:0]         den_reg;
    logic [3:0][VW-1:0]    rem_reg;
    logic [3:0][CW-1:0]    sh_reg;
    logic [3:0][VW-1:0]    rem_next;
    logic [3:0][CW-1:0]    sh_next;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        logic [VW:0] cat;
        logic [VW:0] dif;
        logic        ge;
        for (int k = 0; k < 4; k++)
        begin
            cat         = {in_rem[k], in_sh[k][CW-1]};
            dif         = cat - {1'b0, in_den};
            ge          = cat >= {1'b0, in_den};
            rem_next[k] = ge ? dif[VW-1:0] : cat[VW-1:0];
            sh_next[k]  = {in_sh[k][CW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pts_reg <= in_pts;
            den_reg <= in_den;
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_pts = pts_reg;
    assign out_den = den_reg;
    assign out_rem = rem_reg;
    assign out_sh  = sh_reg;

endmodule

### hdl/hec_plane.sv
// ----------------------------------------------------------------------------
// hec_plane
// Clips an edge against one plane: distances and setup, the offset product,
// a chain of division steps, then the moved endpoint is written back.
// ----------------------------------------------------------------------------
module hec_plane #(
    parameter int CW    = 32,
    parameter int PLANE = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  hec_pkg::hec_ctl_t     in_ctl,
    input  logic [7:0][CW-1:0]    in_pts,
    output hec_pkg::hec_ctl_t     out_ctl,
    output logic [7:0][CW-1:0]    out_pts
);

    localparam int DW  = CW + 1;
    localparam int VW  = CW + 2;
    localparam int PW  = 2 * CW + 1;
    localparam int CI  = PLANE / 2;
    localparam bit SUB = (PLANE % 2) == 1;

    // ---------------- setup stage ----------------
    logic [DW-1:0]         da;
    logic [DW-1:0]         db;
    logic                  neg_a;
    logic                  neg_b;
    hec_pkg::hec_ctl_t     s0_ctl_next;
    logic [DW-1:0]         s0_um_next;
    logic [VW-1:0]         s0_ud_next;
    logic [3:0][CW-1:0]    s0_mag_next;

    hec_pkg::hec_ctl_t     s0_ctl_reg;
    logic [7:0][CW-1:0]    s0_pts_reg;
    logic [DW-1:0]         s0_um_reg;
    logic [VW-1:0]         s0_ud_reg;
    logic [3:0][CW-1:0]    s0_mag_reg;

    always_comb
    begin
        logic [DW-1:0] wa;
        logic [DW-1:0] ca;
        logic [DW-1:0] wb;
        logic [DW-1:0] cb;
        logic [DW-1:0] diff;
        logic [CW-1:0] m;
        logic [CW-1:0] o;
        wa = {in_pts[hec_pkg::W_AXIS][CW-1], in_pts[hec_pkg::W_AXIS]};
        ca = {in_pts[CI][CW-1], in_pts[CI]};
        wb = {in_pts[4 + hec_pkg::W_AXIS][CW-1], in_pts[4 + hec_pkg::W_AXIS]};
        cb = {in_pts[4 + CI][CW-1], in_pts[4 + CI]};
        da = SUB ? wa - ca : wa + ca;
        db = SUB ? wb - cb : wb + cb;
        neg_a = da[DW-1];
        neg_b = db[DW-1];

        s0_ctl_next        = '0;
        s0_ctl_next.valid  = in_ctl.valid;
        s0_ctl_next.kept   = in_ctl.kept & ~(neg_a & neg_b);
        s0_ctl_next.active = in_ctl.kept & (neg_a ^ neg_b);
        s0_ctl_next.move_a = neg_a;

        // Magnitude of the outside distance and of the distance span
        s0_um_next = neg_a ? DW'(0) - da : DW'(0) - db;
        s0_ud_next = neg_a ? {db[DW-1], db} - {da[DW-1], da}
                           : {da[DW-1], da} - {db[DW-1], db};

        for (int k = 0; k < 4; k++)
        begin
            m = neg_a ? in_pts[k] : in_pts[4 + k];
            o = neg_a ? in_pts[4 + k] : in_pts[k];
            diff = {o[CW-1], o} - {m[CW-1], m};
            s0_ctl_next.dneg[k] = diff[DW-1];
            s0_mag_next[k] = diff[DW-1] ? CW'(DW'(0) - diff) : diff[CW-1:0];
        end
    end

    // ---------------- product stage ----------------
    logic [3:0][PW-1:0]    prod;
    hec_pkg::hec_ctl_t     s1_ctl_reg;
    logic [7:0][CW-1:0]    s1_pts_reg;
    logic [VW-1:0]         s1_den_reg;
    logic [3:0][VW-1:0]    s1_rem_reg;
    logic [3:0][CW-1:0]    s1_sh_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod[k] = PW'(s0_mag_reg[k]) * PW'(s0_um_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
            s1_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s0_ctl_reg <= s0_ctl_next;
            s1_ctl_reg <= s0_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_pts_reg <= in_pts;
            s0_um_reg  <= s0_um_next;
            s0_ud_reg  <= s0_ud_next;
            s0_mag_reg <= s0_mag_next;
            s1_pts_reg <= s0_pts_reg;
            s1_den_reg <= s0_ud_reg;
            for (int k = 0; k < 4; k++)
            begin
                // Upper half starts the remainder, lower half is shifted in
                s1_rem_reg[k] <= VW'(prod[k][PW-1:CW]);
                s1_sh_reg[k]  <= prod[k][CW-1:0];
            end
        end
    end

    // ---------------- division chain ----------------
    hec_pkg::hec_ctl_t     dv_ctl [0:CW];
    logic [7:0][CW-1:0]    dv_pts [0:CW];
    logic [VW-1:0]         dv_den [0:CW];
    logic [3:0][VW-1:0]    dv_rem [0:CW];
    logic [3:0][CW-1:0]    dv_sh  [0:CW];

    assign dv_ctl[0] = s1_ctl_reg;
    assign dv_pts[0] = s1_pts_reg;
    assign dv_den[0] = s1_den_reg;
    assign dv_rem[0] = s1_rem_reg;
    assign dv_sh[0]  = s1_sh_reg;

    for (genvar j = 0; j < CW; j++)
    begin : g_div
        hec_div_step #(
            .CW (CW)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_ctl  (dv_ctl[j]),
            .in_pts  (dv_pts[j]),
            .in_den  (dv_den[j]),
            .in_rem  (dv_rem[j]),
            .in_sh   (dv_sh[j]),
            .out_ctl (dv_ctl[j+1]),
            .out_pts (dv_pts[j+1]),
            .out_den (dv_den[j+1]),
            .out_rem (dv_rem[j+1]),
            .out_sh  (dv_sh[j+1])
        );
    end

    // ---------------- write-back stage ----------------
    hec_pkg::hec_ctl_t     u_ctl_reg;
    logic [7:0][CW-1:0]    u_pts_reg;
    logic [7:0][CW-1:0]    u_pts_next;

    always_comb
    begin
        hec_pkg::hec_ctl_t c;
        logic [DW-1:0]     off;
        logic [DW-1:0]     mnew;
        logic [CW-1:0]     m;
        c          = dv_ctl[CW];
        u_pts_next = dv_pts[CW];
        for (int k = 0; k < 4; k++)
        begin
            off  = c.dneg[k] ? DW'(0) - {1'b0, dv_sh[CW][k]} : {1'b0, dv_sh[CW][k]};
            m    = c.move_a ? dv_pts[CW][k] : dv_pts[CW][4 + k];
            mnew = {m[CW-1], m} + off;
            if (c.active && c.move_a)
            begin
                u_pts_next[k] = mnew[CW-1:0];
            end
            else if (c.active)
            begin
                u_pts_next[4 + k] = mnew[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_ctl_reg <= '0;
        end
        else if (adv)
        begin
            u_ctl_reg <= dv_ctl[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_pts_reg <= u_pts_next;
        end
    end

    assign out_ctl = u_ctl_reg;
    assign out_pts = u_pts_reg;

endmodule

### hdl/homogeneous_edge_clipper_unit.sv
// ----------------------------------------------------------------------------
// homogeneous_edge_clipper_unit
// Clips one edge in clip space against the six planes w+x, w-x, w+y, w-y,
// w+z, w-z, in that order, moving an outside endpoint onto the plane.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | start_x..start_w, end_x..end_w
//   output  | out_valid / out_ready| edge_kept, clipped_start_*, clipped_end_*
//
// One item enters per cycle while the output register can take. Each plane
// takes a setup stage, a product stage, COORD_BITS restoring division steps
// (one quotient bit per step) and a write-back stage; the output register
// comes last. Reset clears only control words and the output valid bit. When
// the output register holds an item that is not taken, every stage holds.
// ----------------------------------------------------------------------------
module homogeneous_edge_clipper_unit #(
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] start_z,
    input  logic signed [COORD_BITS-1:0] start_w,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] end_z,
    input  logic signed [COORD_BITS-1:0] end_w,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         edge_kept,
    output logic signed [COORD_BITS-1:0] clipped_start_x,
    output logic signed [COORD_BITS-1:0] clipped_start_y,
    output logic signed [COORD_BITS-1:0] clipped_start_z,
    output logic signed [COORD_BITS-1:0] clipped_start_w,
    output logic signed [COORD_BITS-1:0] clipped_end_x,
    output logic signed [COORD_BITS-1:0] clipped_end_y,
    output logic signed [COORD_BITS-1:0] clipped_end_z,
    output logic signed [COORD_BITS-1:0] clipped_end_w
);

    localparam int CW = COORD_BITS;
    localparam int NP = hec_pkg::NUM_PLANES;

    // Global advance: every stage moves when the output register can take
    logic adv;

    hec_pkg::hec_ctl_t     pl_ctl [0:NP];
    logic [7:0][CW-1:0]    pl_pts [0:NP];
    logic [NP-1:0]         plane_valid;
    logic                  last_valid;

    logic                  out_valid_reg;
    logic                  edge_kept_reg;
    logic [7:0][CW-1:0]    out_pts_reg;
    logic [7:0][CW-1:0]    out_pts_next;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Feed plane 0: an item enters alive, nothing decided yet
    always_comb
    begin
        pl_ctl[0]       = '0;
        pl_ctl[0].valid = in_valid;
        pl_ctl[0].kept  = 1'b1;
    end

    assign pl_pts[0] = {end_w, end_z, end_y, end_x,
                        start_w, start_z, start_y, start_x};

    for (genvar p = 0; p < NP; p++)
    begin : g_plane
        hec_plane #(
            .CW    (CW),
            .PLANE (p)
        ) u_plane (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_ctl  (pl_ctl[p]),
            .in_pts  (pl_pts[p]),
            .out_ctl (pl_ctl[p+1]),
            .out_pts (pl_pts[p+1])
        );
        assign plane_valid[p] = pl_ctl[p+1].valid;
    end

    assign last_valid = pl_ctl[NP].valid;

    // Drop the coordinates of an edge that fell outside a plane. Moved points
    // stay between the two endpoints, so they always fit the field range.
    assign out_pts_next = pl_ctl[NP].kept ? pl_pts[NP] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            edge_kept_reg <= pl_ctl[NP].kept;
            out_pts_reg   <= out_pts_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign edge_kept       = edge_kept_reg;
    assign clipped_start_x = out_pts_reg[0];
    assign clipped_start_y = out_pts_reg[1];
    assign clipped_start_z = out_pts_reg[2];
    assign clipped_start_w = out_pts_reg[3];
    assign clipped_end_x   = out_pts_reg[4];
    assign clipped_end_y   = out_pts_reg[5];
    assign clipped_end_z   = out_pts_reg[6];
    assign clipped_end_w   = out_pts_reg[7];

`ifndef SYNTHESIS
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !edge_kept |-> clipped_start_x == '0 && clipped_start_w == '0
            && clipped_end_x == '0 && clipped_end_w == '0)
        else $error("dropped edge carries nonzero coordinates");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(plane_valid))
        else $error("pipeline valid bits moved during a stall");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(last_valid))
        else $error("output became valid without an item leaving the last plane");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for homogeneous_edge_clipper_unit. Edges are driven over
// a valid/ready channel. A scoreboard predicts the six-plane clip of every
// accepted item and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CB         = 32;
    localparam int ONE        = 32'h0001_0000;
    localparam int LATENCY    = 6 * (CB + 3) + 1;
    localparam int STALL_LIM  = 20000;
    localparam int N_RANDOM   = 430;

    typedef struct packed {
        logic                 kept;
        logic [7:0][CB-1:0]   pt;   // start x,y,z,w then end x,y,z,w
    } clip_res_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the expected clip results in acceptance order.
    // ------------------------------------------------------------------------
    class edge_scoreboard;
        clip_res_t clip_q[$];
        int        errors;
        int        n_kept;
        int        n_dropped;

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint plane_dist(longint p[4], int plane);
            longint c;
            c = p[plane >> 1];
            return (plane & 1) ? p[hec_pkg::W_AXIS] - c : p[hec_pkg::W_AXIS] + c;
        endfunction

        // Slide point m toward o by (o - m) * dm / dden, quotient toward zero.
        function void slide(ref longint m[4], input longint o[4],
                            input longint dm, input longint dden);
            logic [127:0] prod;
            logic [127:0] quo;
            longint       diff;
            bit           tneg;
            bit           neg;
            tneg = (dm < 0) != (dden < 0);
            for (int k = 0; k < 4; k++) begin
                diff = o[k] - m[k];
                prod = 128'(mag(diff)) * 128'(mag(dm));
                quo  = prod / 128'(mag(dden));
                neg  = (diff < 0) != tneg;
                m[k] = neg ? m[k] - longint'(quo[63:0]) : m[k] + longint'(quo[63:0]);
            end
        endfunction

        function logic [CB-1:0] sat(longint v);
            if (v > 64'sd2147483647)
                return 32'h7fff_ffff;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return v[CB-1:0];
        endfunction

        // Note an accepted edge: predict its clip and queue the result.
        function void note_edge(logic signed [CB-1:0] s[4], logic signed [CB-1:0] e[4]);
            longint    a[4];
            longint    b[4];
            longint    da;
            longint    db;
            clip_res_t r;
            r.kept = 1'b1;
            for (int k = 0; k < 4; k++) begin
                a[k] = s[k];
                b[k] = e[k];
            end
            for (int p = 0; p < hec_pkg::NUM_PLANES; p++) begin
                da = plane_dist(a, p);
                db = plane_dist(b, p);
                if (da < 0 && db < 0) begin
                    r.kept = 1'b0;
                    break;
                end
                if (da < 0)
                    slide(a, b, da, da - db);
                else if (db < 0)
                    slide(b, a, db, db - da);
            end
            for (int k = 0; k < 4; k++) begin
                r.pt[k]     = r.kept ? sat(a[k]) : '0;
                r.pt[4 + k] = r.kept ? sat(b[k]) : '0;
            end
            if (r.kept)
                n_kept++;
            else
                n_dropped++;
            clip_q.insert(clip_q.size(), r);
        endfunction

        function void report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endfunction

        // Check one result against the oldest expectation.
        function void check_result(clip_res_t got);
            clip_res_t exp_r;
            if (clip_q.size() == 0) begin
                report("result with no edge pending");
                return;
            end
            exp_r = clip_q.pop_front();
            if (got.kept !== exp_r.kept)
                report($sformatf("edge_kept got %0b exp %0b", got.kept, exp_r.kept));
            for (int k = 0; k < 8; k++)
                if (got.pt[k] !== exp_r.pt[k])
                    report($sformatf("%s_%s got %h exp %h",
                                     (k < 4) ? "start" : "end",
                                     (k % 4 == 0) ? "x" : (k % 4 == 1) ? "y" :
                                     (k % 4 == 2) ? "z" : "w",
                                     got.pt[k], exp_r.pt[k]));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [CB-1:0] start_x, start_y, start_z, start_w;
    logic signed [CB-1:0] end_x, end_y, end_z, end_w;
    logic                 out_valid;
    logic                 out_ready;
    logic                 edge_kept;
    logic signed [CB-1:0] clipped_start_x, clipped_start_y, clipped_start_z, clipped_start_w;
    logic signed [CB-1:0] clipped_end_x, clipped_end_y, clipped_end_z, clipped_end_w;

    edge_scoreboard sb = new();

    bit quiet;      // no idling on either side while set
    bit hold_req;   // ask the receiver for a long hold-off
    int n_sent;
    int stall_cnt;

    homogeneous_edge_clipper_unit #(.COORD_BITS(CB)) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .start_x         (start_x),
        .start_y         (start_y),
        .start_z         (start_z),
        .start_w         (start_w),
        .end_x           (end_x),
        .end_y           (end_y),
        .end_z           (end_z),
        .end_w           (end_w),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .edge_kept       (edge_kept),
        .clipped_start_x (clipped_start_x),
        .clipped_start_y (clipped_start_y),
        .clipped_start_z (clipped_start_z),
        .clipped_start_w (clipped_start_w),
        .clipped_end_x   (clipped_end_x),
        .clipped_end_y   (clipped_end_y),
        .clipped_end_z   (clipped_end_z),
        .clipped_end_w   (clipped_end_w)
    );

    // Free-running 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both channels at the edge; all drives are nonblocking, so the
    // values seen here are the ones the block saw at this edge.
    always @(posedge clk)
    begin
        logic signed [CB-1:0] s[4];
        logic signed [CB-1:0] e[4];
        clip_res_t            got;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                s = '{start_x, start_y, start_z, start_w};
                e = '{end_x, end_y, end_z, end_w};
                sb.note_edge(s, e);
            end
            if (out_valid && out_ready) begin
                got.kept = edge_kept;
                got.pt   = {clipped_end_w, clipped_end_z, clipped_end_y, clipped_end_x,
                            clipped_start_w, clipped_start_z, clipped_start_y,
                            clipped_start_x};
                sb.check_result(got);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIM) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIM);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: idle with a chance of ten percent, hold off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                // Hold off long enough for an item to reach the output register and stall input
                out_ready <= 1'b0;
                repeat (2 * LATENCY) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
        end
    end

    // Offer one edge and hold it until accepted
    task automatic send_edge(logic signed [CB-1:0] s[4], logic signed [CB-1:0] e[4]);
        in_valid <= 1'b1;
        {start_x, start_y, start_z, start_w} <= {s[0], s[1], s[2], s[3]};
        {end_x, end_y, end_z, end_w}         <= {e[0], e[1], e[2], e[3]};
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        n_sent++;
        if (!quiet && $urandom_range(0, 99) < 10) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.clip_q.size() != 0)
            @(posedge clk);
    endtask

    // Random point near the view volume, scaled by a random w, negative one time in ten
    task automatic near_point(output logic signed [CB-1:0] p[4]);
        int w;
        w = $urandom_range(32'h100, 32'h80000);
        for (int k = 0; k < 3; k++)
            p[k] = int'($urandom_range(0, 6 * w)) - 3 * w;
        p[3] = ($urandom_range(0, 9) == 0) ? -w : w;
    endtask

    initial
    begin
        logic signed [CB-1:0] s[4];
        logic signed [CB-1:0] e[4];
        int                   ax;
        int                   sgn;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        n_sent   = 0;
        {start_x, start_y, start_z, start_w} = '0;
        {end_x, end_y, end_z, end_w}         = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both endpoints inside: nothing moves
        s = '{0, 0, 0, ONE};
        e = '{ONE / 2, -ONE / 2, 0, ONE};
        send_edge(s, e);
        // Each plane: both outside (dropped), then one endpoint outside
        for (int p = 0; p < hec_pkg::NUM_PLANES; p++) begin
            ax  = p >> 1;
            sgn = (p & 1) ? 1 : -1;
            s = '{0, 0, 0, ONE};
            e = '{0, 0, 0, ONE};
            s[ax] = sgn * 2 * ONE;
            e[ax] = sgn * 3 * ONE;
            send_edge(s, e);
            e[ax] = 0;
            if (p & 1)
                send_edge(s, e);
            else
                send_edge(e, s);
        end
        // Points exactly on a plane count as inside
        s = '{ONE, 0, 0, ONE};
        e = '{-ONE, 0, 0, ONE};
        send_edge(s, e);
        // Field extremes and negative w
        s = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        e = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_edge(s, e);
        send_edge(e, s);
        s = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        e = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff};
        send_edge(s, e);
        s = '{0, 0, 0, -ONE};
        e = '{ONE, ONE, ONE, -ONE};
        send_edge(s, e);

        // Random part: mostly edges near the frustum, some raw bit patterns
        for (int i = 0; i < N_RANDOM; i++) begin
            quiet = (i >= 40 && i < 120);
            if (i == 160)
                hold_req = 1'b1;
            if (i == 300)
                drain();
            if ($urandom_range(0, 3) == 0) begin
                for (int k = 0; k < 4; k++) begin
                    s[k] = $urandom;
                    e[k] = $urandom;
                end
            end else begin
                near_point(s);
                near_point(e);
            end
            send_edge(s, e);
        end
        quiet = 1'b0;
        drain();
        repeat (LATENCY + 20) @(posedge clk);

        $display("run: %0d edges sent, %0d kept and %0d dropped by prediction",
                 n_sent, sb.n_kept, sb.n_dropped);
        $display("covered all six planes, on-plane points, extremes, a full-pipe stall");
        if (sb.errors == 0 && sb.clip_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
